/* sv/spl_pkg.sv */
// Package with the types, codes and address helpers of the sorted priority list.
package spl_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [2:0] OP_INSERT   = 3'd0;
   localparam logic [2:0] OP_REM_HEAD = 3'd1;
   localparam logic [2:0] OP_REM_TAIL = 3'd2;
   localparam logic [2:0] OP_READ     = 3'd3;
   localparam logic [2:0] OP_CLEAR    = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [15:0] priority_req;
      logic [31:0]        payload;
      logic [5:0]         index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [15:0] out_priority;
      logic [31:0]        out_payload;
      logic [6:0]         entries;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] pri;
      logic [31:0]        pay;
   } entry_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_INS_HEAD,
      FSM_INS_TAIL,
      FSM_WALK,
      FSM_FETCH,
      FSM_DONE
   } fsm_type;

   function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0] offs);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(offs);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return ADDR_W'(sum);
   endfunction

   function automatic logic [ADDR_W-1:0] addr_dec(input logic [ADDR_W-1:0] base);
      logic [ADDR_W-1:0] res;
      if (base == '0) begin
         res = ADDR_W'(DEPTH - 1);
      end else begin
         res = base - ADDR_W'(1);
      end
      return res;
   endfunction

endpackage

/* sv/sorted_priority_list_top.sv */
// Sorted priority list held in a circular buffer memory, with its control sequencer.
// Clear, unknown, full and empty transactions go straight to done; removes and reads fetch
// the entry through the single read port of the entry memory; an insert into an empty list
// writes at once, others read head and tail, then move each entry of higher priority one
// place toward the tail. One transaction is in work at a time; the next is taken once the
// result is in the output register. Reset empties the list and holds no result.
module sorted_priority_list_top
   import spl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   entry_type mem [DEPTH];

   fsm_type            state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic signed [15:0] head_pri_ff, head_pri_in;
   req_type            req_ff, req_in;
   entry_type          rd_q_ff;
   logic [1:0]         res_status_ff, res_status_in;
   entry_type          res_entry_ff, res_entry_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic              req_take;
   logic              rsp_load;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [ADDR_W-1:0] rd_addr;
   entry_type         new_entry;

   assign req_stall = (state_ff != FSM_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == FSM_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign new_entry = '{pri: req_ff.priority_req, pay: req_ff.payload};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_take) begin
               priority if (req_data.op == OP_INSERT) begin
                  if (count_ff == CNT_W'(DEPTH) || count_ff == '0) begin
                     state_in = FSM_DONE;
                  end else begin
                     state_in = FSM_INS_HEAD;
                  end
               end else if (req_data.op == OP_REM_HEAD || req_data.op == OP_REM_TAIL) begin
                  state_in = (count_ff == '0) ? FSM_DONE : FSM_FETCH;
               end else if (req_data.op == OP_READ) begin
                  if (count_ff == '0 || 32'(req_data.index) >= 32'(count_ff)) begin
                     state_in = FSM_DONE;
                  end else begin
                     state_in = FSM_FETCH;
                  end
               end else begin
                  state_in = FSM_DONE;
               end
            end
         end
         FSM_INS_HEAD: state_in = FSM_INS_TAIL;
         FSM_INS_TAIL: begin
            if (req_ff.priority_req >= rd_q_ff.pri || req_ff.priority_req <= head_pri_ff) begin
               state_in = FSM_DONE;
            end else begin
               state_in = FSM_WALK;
            end
         end
         FSM_WALK: begin
            if (!(rd_q_ff.pri > req_ff.priority_req)) begin
               state_in = FSM_DONE;
            end
         end
         FSM_FETCH: state_in = FSM_DONE;
         FSM_DONE: begin
            if (rsp_load) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      head_in       = head_ff;
      j_in          = j_ff;
      head_pri_in   = head_pri_ff;
      req_in        = req_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      wr_data       = new_entry;
      rd_addr       = head_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_take) begin
               req_in        = req_data;
               res_status_in = ST_OK;
               res_entry_in  = '0;
               priority if (req_data.op == OP_INSERT) begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     res_status_in = ST_FULL;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = head_ff;
                     wr_data  = '{pri: req_data.priority_req, pay: req_data.payload};
                     count_in = CNT_W'(1);
                  end
               end else if (req_data.op == OP_REM_HEAD) begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_addr  = head_ff;
                     head_in  = phys_addr(head_ff, CNT_W'(1));
                     count_in = count_ff - CNT_W'(1);
                  end
               end else if (req_data.op == OP_REM_TAIL) begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_addr  = phys_addr(head_ff, count_ff - CNT_W'(1));
                     count_in = count_ff - CNT_W'(1);
                  end
               end else if (req_data.op == OP_READ) begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else if (32'(req_data.index) >= 32'(count_ff)) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     rd_addr = phys_addr(head_ff, CNT_W'(req_data.index));
                  end
               end else if (req_data.op == OP_CLEAR) begin
                  count_in = '0;
               end
            end
         end
         FSM_INS_HEAD: begin
            head_pri_in = rd_q_ff.pri;
            rd_addr     = phys_addr(head_ff, count_ff - CNT_W'(1));
         end
         FSM_INS_TAIL: begin
            priority if (req_ff.priority_req >= rd_q_ff.pri) begin
               wr_en    = 1'b1;
               wr_addr  = phys_addr(head_ff, count_ff);
               count_in = count_ff + CNT_W'(1);
            end else if (req_ff.priority_req <= head_pri_ff) begin
               wr_en    = 1'b1;
               wr_addr  = addr_dec(head_ff);
               head_in  = addr_dec(head_ff);
               count_in = count_ff + CNT_W'(1);
            end else begin
               wr_en   = 1'b1;
               wr_addr = phys_addr(head_ff, count_ff);
               wr_data = rd_q_ff;
               rd_addr = phys_addr(head_ff, count_ff - CNT_W'(2));
               j_in    = count_ff - CNT_W'(2);
            end
         end
         FSM_WALK: begin
            wr_en   = 1'b1;
            wr_addr = phys_addr(head_ff, j_ff + CNT_W'(1));
            if (rd_q_ff.pri > req_ff.priority_req) begin
               wr_data = rd_q_ff;
               rd_addr = phys_addr(head_ff, j_ff - CNT_W'(1));
               j_in    = j_ff - CNT_W'(1);
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         FSM_FETCH: res_entry_in = rd_q_ff;
         FSM_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_in.status       = res_status_ff;
         rsp_in.out_priority = res_entry_ff.pri;
         rsp_in.out_payload  = res_entry_ff.pay;
         rsp_in.entries      = 7'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff          <= j_in;
      head_pri_ff   <= head_pri_in;
      req_ff        <= req_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_ff        <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("entry count exceeds the list depth");

   a_walk_stops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_WALK && rd_q_ff.pri > req_ff.priority_req) |-> (j_ff != '0))
      else $error("insert walk moved past the head");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.op == OP_INSERT && count_ff == CNT_W'(DEPTH))
      |=> (count_ff == CNT_W'(DEPTH) && state_ff == FSM_DONE))
      else $error("insert into a full list changed the count");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == FSM_DONE))
      else $error("result transaction raised outside the done state");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority list top level.
module testbench;
   import spl_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_LENGTH  = 300;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int req_idle_pct   = 0;
   int rsp_stall_pct  = 0;
   int hold_cycles    = 0;
   int mismatch_count = 0;

   logic signed [15:0] list_pri [DEPTH];
   logic [31:0]        list_pay [DEPTH];
   int                 list_count = 0;
   rsp_type            awaited_responses [$];

   sorted_priority_list_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   function automatic rsp_type list_response(input req_type r);
      rsp_type            res;
      logic signed [15:0] p;
      int                 pos;
      int                 i;
      res = '0;
      p = r.priority_req;
      case (r.op)
         OP_INSERT: begin
            if (list_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               if (list_count == 0 || p >= list_pri[list_count-1]) begin
                  pos = list_count;
               end else if (p <= list_pri[0]) begin
                  pos = 0;
               end else begin
                  pos = 1;
                  while (pos < list_count && list_pri[pos] <= p) pos++;
               end
               for (i = list_count; i > pos; i--) begin
                  list_pri[i] = list_pri[i-1];
                  list_pay[i] = list_pay[i-1];
               end
               list_pri[pos] = p;
               list_pay[pos] = r.payload;
               list_count++;
            end
         end
         OP_REM_HEAD: begin
            if (list_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.out_priority = list_pri[0];
               res.out_payload  = list_pay[0];
               for (i = 1; i < list_count; i++) begin
                  list_pri[i-1] = list_pri[i];
                  list_pay[i-1] = list_pay[i];
               end
               list_count--;
            end
         end
         OP_REM_TAIL: begin
            if (list_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               list_count--;
               res.out_priority = list_pri[list_count];
               res.out_payload  = list_pay[list_count];
            end
         end
         OP_READ: begin
            if (list_count == 0) begin
               res.status = ST_EMPTY;
            end else if (int'(r.index) >= list_count) begin
               res.status = ST_RANGE;
            end else begin
               res.out_priority = list_pri[r.index];
               res.out_payload  = list_pay[r.index];
            end
         end
         OP_CLEAR: begin
            list_count = 0;
         end
         default: begin
         end
      endcase
      res.entries = 7'(list_count);
      return res;
   endfunction

   function automatic req_type make_req(input logic [2:0] op, input logic [15:0] pri,
                                        input logic [31:0] pay, input logic [5:0] idx);
      req_type r;
      r.op           = op;
      r.priority_req = pri;
      r.payload      = pay;
      r.index        = idx;
      return r;
   endfunction

   // Inserts dominate while the list is short so that it fills, ties and the
   // current head and tail priorities are favored, and most reads stay in range.
   function automatic req_type random_request();
      req_type r;
      int      ins_pct;
      int      roll;
      int      v;
      r.payload      = $urandom;
      r.index        = 6'($urandom);
      r.priority_req = 16'($urandom);
      ins_pct = (list_count < 8) ? 70 : ((list_count > 56) ? 35 : 50);
      if ($urandom_range(99) < ins_pct) begin
         r.op = OP_INSERT;
      end else begin
         roll = $urandom_range(99);
         if (roll < 25) begin
            r.op = OP_REM_HEAD;
         end else if (roll < 45) begin
            r.op = OP_REM_TAIL;
         end else if (roll < 92) begin
            r.op = OP_READ;
         end else if (roll < 95) begin
            r.op = OP_CLEAR;
         end else begin
            r.op = 3'($urandom_range(7, 5));
         end
      end
      case ($urandom_range(3))
         1: begin
            v = $urandom_range(8);
            r.priority_req = 16'(v - 4);
         end
         2: begin
            if (list_count > 0) begin
               r.priority_req = $urandom_range(1) ? list_pri[0] : list_pri[list_count-1];
            end
         end
         3: begin
            r.priority_req = $urandom_range(1) ? 16'h7FFF : 16'h8000;
         end
         default: begin
         end
      endcase
      if (list_count > 0 && $urandom_range(99) < 80) begin
         r.index = 6'($urandom_range(list_count - 1));
      end
      return r;
   endfunction

   task automatic send_transaction(input req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(posedge clock);
      end while (req_stall);
      awaited_responses.push_back(list_response(r));
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      req_idle_pct  = sender_pct;
      rsp_stall_pct = receiver_pct;
   endtask

   task automatic test_directed();
      send_transaction(make_req(OP_REM_HEAD, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(OP_REM_TAIL, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(OP_READ, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(OP_READ, 16'hFFFF, 32'hFFFFFFFF, 6'd63));
      send_transaction(make_req(OP_INSERT, 16'h0000, 32'h00000000, 6'd0));
      send_transaction(make_req(OP_INSERT, 16'h7FFF, 32'hFFFFFFFF, 6'd63));
      send_transaction(make_req(OP_INSERT, 16'h8000, 32'h00000001, 6'd0));
      send_transaction(make_req(OP_INSERT, 16'h8000, 32'h00000002, 6'd0));
      send_transaction(make_req(OP_INSERT, 16'h7FFF, 32'h00000003, 6'd0));
      send_transaction(make_req(OP_INSERT, 16'h0000, 32'h00000004, 6'd0));
      send_transaction(make_req(OP_INSERT, 16'h0064, 32'h00000005, 6'd0));
      send_transaction(make_req(OP_READ, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(OP_READ, 16'h0000, 32'h0, 6'd6));
      send_transaction(make_req(OP_READ, 16'h0000, 32'h0, 6'd7));
      send_transaction(make_req(OP_READ, 16'h0000, 32'h0, 6'd63));
      send_transaction(make_req(OP_REM_HEAD, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(OP_REM_TAIL, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(3'd5, 16'hFFFF, 32'hFFFFFFFF, 6'd63));
      send_transaction(make_req(3'd6, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(3'd7, 16'h8000, 32'h80000000, 6'd32));
      send_transaction(make_req(OP_CLEAR, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(OP_CLEAR, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(OP_READ, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(OP_REM_TAIL, 16'h0000, 32'h0, 6'd0));
   endtask

   task automatic test_full_list();
      int n;
      send_transaction(make_req(OP_CLEAR, 16'h0000, 32'h0, 6'd0));
      for (n = 0; n < DEPTH; n++) begin
         send_transaction(make_req(OP_INSERT, 16'($urandom_range(7)), $urandom, 6'($urandom)));
      end
      send_transaction(make_req(OP_INSERT, 16'h7FFF, 32'hFFFFFFFF, 6'd63));
      send_transaction(make_req(OP_INSERT, 16'h8000, 32'h00000000, 6'd0));
      send_transaction(make_req(OP_READ, 16'h0000, 32'h0, 6'd63));
      send_transaction(make_req(OP_READ, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(OP_REM_TAIL, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(OP_INSERT, 16'h7FFF, 32'h12345678, 6'd0));
      send_transaction(make_req(OP_INSERT, 16'h8000, 32'h87654321, 6'd0));
      send_transaction(make_req(OP_REM_HEAD, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(OP_REM_HEAD, 16'h0000, 32'h0, 6'd0));
      send_transaction(make_req(OP_CLEAR, 16'h0000, 32'h0, 6'd0));
   endtask

   task automatic test_random(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         send_transaction(random_request());
      end
   endtask

   task automatic test_backpressure();
      int n;
      hold_cycles = HOLD_LENGTH;
      for (n = 0; n < 30; n++) begin
         send_transaction(random_request());
      end
   endtask

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            exp_rsp = awaited_responses.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $display("%0t: status: expected %0d, actual %0d",
                        $time, exp_rsp.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.out_priority !== exp_rsp.out_priority) begin
               $display("%0t: out_priority: expected %0d, actual %0d",
                        $time, exp_rsp.out_priority, rsp_data.out_priority);
               mismatch_count++;
            end
            if (rsp_data.out_payload !== exp_rsp.out_payload) begin
               $display("%0t: out_payload: expected %h, actual %h",
                        $time, exp_rsp.out_payload, rsp_data.out_payload);
               mismatch_count++;
            end
            if (rsp_data.entries !== exp_rsp.entries) begin
               $display("%0t: entries: expected %0d, actual %0d",
                        $time, exp_rsp.entries, rsp_data.entries);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_idling(33, 33);
      test_directed();
      set_idling(0, 0);
      test_full_list();
      test_random(95);
      set_idling(66, 0);
      test_random(95);
      set_idling(0, 66);
      test_random(95);
      set_idling(33, 33);
      test_random(95);
      set_idling(0, 0);
      test_backpressure();
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

/* sorted_priority_list_top.f */
sv/spl_pkg.sv
sv/sorted_priority_list_top.sv
dv/testbench.sv
